[rtl/core/tlnef_pkg.sv]
// Shared types and constants for the text line number / escape filter.
// No dependencies; imported by every module under rtl/core.
package tlnef_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int BODY_MAX   = 4;   // widest escape: M-^X
  localparam int BODY_CNT_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd4;

  // numbering modes; the remaining code numbers nothing
  localparam logic [1:0] NUM_NONE     = 2'd0;
  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONBLANK = 2'd2;

  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_I      = 8'h49;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_HIGH   = 8'h80;
  localparam logic [BYTE_W-1:0] CH_M_CTL_END = 8'hA0;  // first byte shown as plain M-X
  localparam logic [BYTE_W-1:0] CH_CTL_OFS   = 8'h40;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       show_ends;
    logic       show_tabs;
    logic       show_nonprinting;
    logic       squeeze_blank;
  } cfg_t;

endpackage

[rtl/core/tlnef_expand.sv]
// Input register, line state and expansion of one byte into its output bytes.
// Depends on tlnef_pkg.
module tlnef_expand #(
  parameter int NUMBER_DIGITS = 6,
  parameter int MAXB          = NUMBER_DIGITS + 1 + tlnef_pkg::BODY_MAX,
  parameter int CNT_W         = $clog2(MAXB + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tlnef_pkg::cfg_t                   cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tlnef_pkg::BYTE_W-1:0]      in_byte,
  input  logic                              in_file_start,
  input  logic                              can_load,
  output logic                              load,
  output logic [CNT_W-1:0]                  ld_count,
  output logic [MAXB-1:0][tlnef_pkg::BYTE_W-1:0] ld_bytes
);
  import tlnef_pkg::*;

  localparam int CW = 4 * NUMBER_DIGITS;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_fs;

  logic          after_newline, after_newline_next;
  logic          printing_on, printing_on_next;
  logic [CW-1:0] line_count, line_count_next;

  logic          an_eff, po_eff;
  logic [CW-1:0] cnt_eff, cnt_inc;
  logic          num, squeezed;
  logic [BODY_MAX-1:0][BYTE_W-1:0] body;
  logic [BODY_CNT_W-1:0]           body_n;
  logic [NUMBER_DIGITS-1:0][BYTE_W-1:0] digit_chr;
  logic                                 seen, carry;
  logic [3:0]                           nib;

  assign in_ready = !s1_valid || can_load;
  assign load     = s1_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
      s1_fs   <= in_file_start;
    end
  end

  // file start restarts the line state ahead of this byte
  always_comb begin
    an_eff  = s1_fs ? 1'b1 : after_newline;
    po_eff  = s1_fs ? 1'b1 : printing_on;
    cnt_eff = s1_fs ? CW'(1) : line_count;
  end

  always_comb begin
    num                = 1'b0;
    squeezed           = 1'b0;
    body               = '0;
    body_n             = '0;
    after_newline_next = an_eff;
    printing_on_next   = po_eff;
    if (s1_byte == CH_NL) begin
      if (an_eff && !po_eff && cfg.squeeze_blank) begin
        squeezed = 1'b1;
      end else begin
        if (an_eff) begin
          num              = (cfg.number_mode == NUM_ALL);
          printing_on_next = 1'b0;
        end else begin
          printing_on_next = 1'b1;
        end
        after_newline_next = 1'b1;
        if (cfg.show_ends) begin
          body[0] = CH_DOLLAR;
          body[1] = CH_NL;
          body_n  = 3'd2;
        end else begin
          body[0] = CH_NL;
          body_n  = 3'd1;
        end
      end
    end else begin
      num = an_eff && (cfg.number_mode == NUM_ALL || cfg.number_mode == NUM_NONBLANK);
      after_newline_next = 1'b0;
      printing_on_next   = 1'b1;
      if (s1_byte == CH_TAB) begin
        if (cfg.show_tabs) begin
          body[0] = CH_CARET;
          body[1] = CH_I;
          body_n  = 3'd2;
        end else begin
          body[0] = CH_TAB;
          body_n  = 3'd1;
        end
      end else if (!cfg.show_nonprinting) begin
        body[0] = s1_byte;
        body_n  = 3'd1;
      end else if (s1_byte < CH_SPACE) begin
        body[0] = CH_CARET;
        body[1] = s1_byte + CH_CTL_OFS;
        body_n  = 3'd2;
      end else if (s1_byte < CH_DEL) begin
        body[0] = s1_byte;
        body_n  = 3'd1;
      end else if (s1_byte == CH_DEL) begin
        body[0] = CH_CARET;
        body[1] = CH_QUEST;
        body_n  = 3'd2;
      end else begin
        body[0] = CH_M;
        body[1] = CH_MINUS;
        if (s1_byte < CH_M_CTL_END) begin
          body[2] = CH_CARET;
          body[3] = s1_byte - CH_CTL_OFS;
          body_n  = 3'd4;
        end else if (s1_byte != 8'hFF) begin
          body[2] = s1_byte - CH_HIGH;
          body_n  = 3'd3;
        end else begin
          body[2] = CH_CARET;
          body[3] = CH_QUEST;
          body_n  = 3'd4;
        end
      end
    end
  end

  // number text, most significant digit first; leading zeros blank
  always_comb begin
    seen = 1'b0;
    nib  = '0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      nib  = cnt_eff[4*(NUMBER_DIGITS-1-i) +: 4];
      seen = seen || (nib != 4'd0) || (i == NUMBER_DIGITS - 1);
      if (nib > 4'd9) nib = 4'd9;
      digit_chr[i] = seen ? (CH_ZERO + BYTE_W'(nib)) : CH_SPACE;
    end
  end

  // BCD increment, wraps after all nines
  always_comb begin
    carry   = 1'b1;
    cnt_inc = cnt_eff;
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      if (carry) begin
        if (cnt_eff[4*d +: 4] >= 4'd9) begin
          cnt_inc[4*d +: 4] = 4'd0;
        end else begin
          cnt_inc[4*d +: 4] = cnt_eff[4*d +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    line_count_next = num ? cnt_inc : cnt_eff;
  end

  always_comb begin
    ld_bytes = '0;
    for (int i = 0; i < MAXB; i++) begin
      if (num) begin
        if (i < NUMBER_DIGITS) begin
          ld_bytes[i] = digit_chr[i];
        end else if (i == NUMBER_DIGITS) begin
          ld_bytes[i] = CH_TAB;
        end else if (i - NUMBER_DIGITS - 1 < BODY_MAX) begin
          ld_bytes[i] = body[i-NUMBER_DIGITS-1];
        end
      end else if (i < BODY_MAX) begin
        ld_bytes[i] = body[i];
      end
    end
    if (squeezed) begin
      ld_count = '0;
    end else if (num) begin
      ld_count = CNT_W'(NUMBER_DIGITS + 1) + CNT_W'(body_n);
    end else begin
      ld_count = CNT_W'(body_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_newline <= 1'b1;
      printing_on   <= 1'b1;
      line_count    <= CW'(1);
    end else if (load) begin
      after_newline <= after_newline_next;
      printing_on   <= printing_on_next;
      line_count    <= line_count_next;
    end
  end

endmodule

[rtl/core/tlnef_serial.sv]
// Result register: holds one expanded run and sends it a byte per beat.
// Depends on tlnef_pkg.
module tlnef_serial #(
  parameter int MAXB  = 11,
  parameter int CNT_W = $clog2(MAXB + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [CNT_W-1:0]                  ld_count,
  input  logic [MAXB-1:0][tlnef_pkg::BYTE_W-1:0] ld_bytes,
  output logic                              can_load,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tlnef_pkg::BYTE_W-1:0]      out_byte,
  output logic                              out_last
);
  import tlnef_pkg::*;

  localparam int POS_W = $clog2(MAXB);

  logic                          busy;
  logic [CNT_W-1:0]              count;
  logic [POS_W-1:0]              pos;
  logic [MAXB-1:0][BYTE_W-1:0]   bytes;

  assign out_valid = busy;
  assign out_byte  = bytes[pos];
  assign out_last  = (CNT_W'(pos) + CNT_W'(1) == count);
  assign can_load  = !busy || (out_last && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (load) begin
      busy <= (ld_count != '0);
      pos  <= '0;
    end else if (busy && out_ready) begin
      if (out_last) begin
        busy <= 1'b0;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
    if (load) begin
      count <= ld_count;
      bytes <= ld_bytes;
    end
  end

  a_pos_in_run: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != '0 && CNT_W'(pos) < count))
    else $error("byte index outside the held run");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("run loaded over one still being sent");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last && !load) |=> !out_valid)
    else $error("output still valid after last beat of run");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last && !load) |=> (pos == $past(pos) + POS_W'(1)))
    else $error("byte index did not advance after beat");

endmodule

[rtl/core/text_line_number_escape_filter_unit.sv]
// Top level of the text line number / escape filter: config registers and
// the expand and serial stages. Depends on tlnef_pkg, tlnef_expand, tlnef_serial.
//
//  channel  | direction | beat contents
//  ---------+-----------+------------------------------------------------
//  cfg      | in        | cfg_index = register, cfg_data = value
//  s_axis   | in        | tdata = data_byte, tuser = file_start
//  m_axis   | out       | tdata = out_byte, tlast = last_of_run
//
// One input byte per cycle when each byte yields one output byte and m_axis is
// not stalled; an input yielding more holds the input while the result register
// sends its run one byte per beat. Bytes go input register, then result register.
// Reset (rst, synchronous) clears all options and restarts the line count.
// Output stalls back up through the result register into the input stage.
module text_line_number_escape_filter_unit #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlnef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlnef_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
  input  logic                               s_axis_tuser,  // [0] file_start
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [7:0] out_byte
  output logic                               m_axis_tlast
);
  import tlnef_pkg::*;

  localparam int MAXB  = NUMBER_DIGITS + 1 + BODY_MAX;
  localparam int CNT_W = $clog2(MAXB + 1);

  cfg_t cfg;

  logic                        can_load, load;
  logic [CNT_W-1:0]            ld_count;
  logic [MAXB-1:0][BYTE_W-1:0] ld_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUMBER_MODE:      cfg.number_mode      <= cfg_data[1:0];
        CFG_SHOW_ENDS:        cfg.show_ends        <= cfg_data[0];
        CFG_SHOW_TABS:        cfg.show_tabs        <= cfg_data[0];
        CFG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data[0];
        CFG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tlnef_expand #(
    .NUMBER_DIGITS(NUMBER_DIGITS),
    .MAXB         (MAXB),
    .CNT_W        (CNT_W)
  ) u_expand (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_byte      (s_axis_tdata),
    .in_file_start(s_axis_tuser),
    .can_load     (can_load),
    .load         (load),
    .ld_count     (ld_count),
    .ld_bytes     (ld_bytes)
  );

  tlnef_serial #(
    .MAXB (MAXB),
    .CNT_W(CNT_W)
  ) u_serial (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .ld_count (ld_count),
    .ld_bytes (ld_bytes),
    .can_load (can_load),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_byte (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule
